// ----- rtl/core/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, constants and stage payload types of the barometer
// compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W   = 24;  // raw conversion width
  localparam int CAL_W   = 16;  // calibration word width
  localparam int IDX_W   = 3;   // register index width
  localparam int DT_W    = 25;  // D2 - C5*2^8
  localparam int MT_W    = 42;  // dT times a calibration word
  localparam int DSQ_W   = 50;  // dT squared
  localparam int TEMP_W  = 20;  // temperature before clamping
  localparam int T2_W    = 18;
  localparam int OFF_W   = 40;  // OFF and SENS
  localparam int SQ_W    = 42;  // squared temperature deviations
  localparam int SPLIT_W = 20;  // low slice of SENS for the split multiply
  localparam int PL_W    = RAW_W + SPLIT_W;
  localparam int PH_W    = RAW_W + 1 + OFF_W - SPLIT_W;
  localparam int PROD_W  = 63;  // D1 * SENS
  localparam int DIFF_W  = 43;  // D1*SENS/2^21 - OFF
  localparam int OT_W    = 15;  // output temperature
  localparam int OP_W    = 17;  // output pressure

  localparam logic signed [TEMP_W-1:0] TEMP_REF_C = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_C = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN_C = -20'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_C = 20'sd8500;
  localparam logic signed [DIFF_W-1:0] PRES_MIN_C = 43'sd1000;
  localparam logic signed [DIFF_W-1:0] PRES_MAX_C = 43'sd120000;

  typedef enum logic [IDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // first-order results
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic        [T2_W-1:0]   t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
  } front_t;

  // second-order corrected results
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
  } second_t;

endpackage

// ----- rtl/core/bptc_front.sv -----
// ----------------------------------------------------------------------------
// bptc_front
// Three stages: dT, the dT products, then first-order TEMP, OFF, SENS and T2.
// ----------------------------------------------------------------------------
module bptc_front
  import bptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  input  cal_t             cal,
  output logic             out_valid,
  input  logic             out_ready,
  output front_t           out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic        [RAW_W-1:0]  d1_s1, d1_s2, d1_s3;
  logic signed [DT_W-1:0]   dt_s1;
  logic signed [MT_W-1:0]   mt_s2, mo_s2, ms_s2;
  logic signed [DSQ_W-1:0]  dsq_s2;
  logic signed [TEMP_W-1:0] temp_s3;
  logic        [T2_W-1:0]   t2_s3;
  logic signed [OFF_W-1:0]  off_s3, sens_s3;

  // a stage advances when empty or when the stage after it advances
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_s1 <= raw_pressure;
      dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});
    end
    if (en2) begin
      d1_s2  <= d1_s1;
      mt_s2  <= MT_W'(dt_s1) * MT_W'($signed({1'b0, cal.c6}));
      mo_s2  <= MT_W'(dt_s1) * MT_W'($signed({1'b0, cal.c4}));
      ms_s2  <= MT_W'(dt_s1) * MT_W'($signed({1'b0, cal.c3}));
      dsq_s2 <= DSQ_W'(dt_s1) * DSQ_W'(dt_s1);
    end
    if (en3) begin
      d1_s3   <= d1_s2;
      temp_s3 <= TEMP_REF_C + TEMP_W'(mt_s2 >>> 23);
      off_s3  <= $signed({8'h00, cal.c2, 16'h0000}) + OFF_W'(mo_s2 >>> 7);
      sens_s3 <= $signed({9'h000, cal.c1, 15'h0000}) + OFF_W'(ms_s2 >>> 8);
      t2_s3   <= T2_W'(dsq_s2 >>> 31);
    end
  end

  assign out_valid     = v3;
  assign out_data.d1   = d1_s3;
  assign out_data.temp = temp_s3;
  assign out_data.t2   = t2_s3;
  assign out_data.off  = off_s3;
  assign out_data.sens = sens_s3;

endmodule

// ----- rtl/core/bptc_second.sv -----
// ----------------------------------------------------------------------------
// bptc_second
// Three stages: squared deviations and the T2 correction of TEMP, OFF2/SENS2
// terms, then the subtraction of the second-order corrections.
// ----------------------------------------------------------------------------
module bptc_second
  import bptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  front_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output second_t out_data
);

  logic v4, v5, v6;
  logic en4, en5, en6;

  logic signed [TEMP_W:0]   e_ref, e_low;
  logic        [SQ_W-1:0]   five_sq, seven_sq, eleven_sq;
  logic        [SQ_W-1:0]   off2_calc, sens2_calc;

  logic        [RAW_W-1:0]  d1_s4, d1_s5, d1_s6;
  logic signed [TEMP_W-1:0] temp_s4, temp_s5, temp_s6;
  logic signed [OFF_W-1:0]  off_s4, off_s5, off_s6;
  logic signed [OFF_W-1:0]  sens_s4, sens_s5, sens_s6;
  logic        [SQ_W-1:0]   sq_ref_s4, sq_low_s4;
  logic                     lt_ref_s4, lt_low_s4;
  logic        [OFF_W-1:0]  off2_s5, sens2_s5;

  assign en6      = !v6 || out_ready;
  assign en5      = !v5 || en6;
  assign en4      = !v4 || en5;
  assign in_ready = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_comb begin
    e_ref = (TEMP_W+1)'(in_data.temp) - (TEMP_W+1)'(TEMP_REF_C);
    e_low = (TEMP_W+1)'(in_data.temp) - (TEMP_W+1)'(TEMP_LOW_C);
  end

  // squares are never negative, so plain shifts give the floor
  always_comb begin
    five_sq   = (sq_ref_s4 << 2) + sq_ref_s4;
    seven_sq  = (sq_low_s4 << 3) - sq_low_s4;
    eleven_sq = (sq_low_s4 << 3) + (sq_low_s4 << 1) + sq_low_s4;
    off2_calc  = '0;
    sens2_calc = '0;
    if (lt_ref_s4) begin
      off2_calc  = five_sq >> 1;
      sens2_calc = five_sq >> 2;
      if (lt_low_s4) begin
        off2_calc  = off2_calc + seven_sq;
        sens2_calc = sens2_calc + (eleven_sq >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      d1_s4     <= in_data.d1;
      off_s4    <= in_data.off;
      sens_s4   <= in_data.sens;
      // T2 applies only below the reference temperature
      temp_s4   <= (in_data.temp < TEMP_REF_C) ?
                   in_data.temp - TEMP_W'($signed({1'b0, in_data.t2})) : in_data.temp;
      sq_ref_s4 <= SQ_W'(SQ_W'(e_ref) * SQ_W'(e_ref));
      sq_low_s4 <= SQ_W'(SQ_W'(e_low) * SQ_W'(e_low));
      lt_ref_s4 <= in_data.temp < TEMP_REF_C;
      lt_low_s4 <= in_data.temp < TEMP_LOW_C;
    end
    if (en5) begin
      d1_s5    <= d1_s4;
      temp_s5  <= temp_s4;
      off_s5   <= off_s4;
      sens_s5  <= sens_s4;
      off2_s5  <= OFF_W'(off2_calc);
      sens2_s5 <= OFF_W'(sens2_calc);
    end
    if (en6) begin
      d1_s6   <= d1_s5;
      temp_s6 <= temp_s5;
      off_s6  <= off_s5 - $signed(off2_s5);
      sens_s6 <= sens_s5 - $signed(sens2_s5);
    end
  end

  assign out_valid     = v6;
  assign out_data.d1   = d1_s6;
  assign out_data.temp = temp_s6;
  assign out_data.off  = off_s6;
  assign out_data.sens = sens_s6;

endmodule

// ----- rtl/core/bptc_press.sv -----
// ----------------------------------------------------------------------------
// bptc_press
// Four stages: split D1*SENS multiply, product merge and temperature clamp,
// offset subtraction, then pressure clamp into the output register.
// ----------------------------------------------------------------------------
module bptc_press
  import bptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  second_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OT_W-1:0] out_temp,
  output logic        [OP_W-1:0] out_pres,
  output logic                   out_flag
);

  logic v7, v8, v9, v10;
  logic en7, en8, en9, en10;

  logic signed [OFF_W-1:0]  off_s7, off_s8;
  logic signed [TEMP_W-1:0] temp_s7;
  logic        [PL_W-1:0]   pl_s7;
  logic signed [PH_W-1:0]   ph_s7;
  logic signed [PROD_W-1:0] prod_s8;
  logic signed [OT_W-1:0]   temp_s8, temp_s9;
  logic                     tflag_s8, tflag_s9;
  logic signed [DIFF_W-1:0] diff_s9;

  logic signed [TEMP_W-1:0] temp_sat;
  logic                     tflag;
  logic signed [DIFF_W-1:0] p_full, p_sat;
  logic                     pflag;

  assign en10     = !v10 || out_ready;
  assign en9      = !v9 || en10;
  assign en8      = !v8 || en9;
  assign en7      = !v7 || en8;
  assign in_ready = en7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      if (en7)  v7  <= in_valid;
      if (en8)  v8  <= v7;
      if (en9)  v9  <= v8;
      if (en10) v10 <= v9;
    end
  end

  always_comb begin
    temp_sat = temp_s7;
    tflag    = 1'b0;
    if (temp_s7 < TEMP_MIN_C) begin
      temp_sat = TEMP_MIN_C;
      tflag    = 1'b1;
    end
    if (temp_s7 > TEMP_MAX_C) begin
      temp_sat = TEMP_MAX_C;
      tflag    = 1'b1;
    end
  end

  always_comb begin
    p_full = diff_s9 >>> 15;
    p_sat  = p_full;
    pflag  = 1'b0;
    if (p_full < PRES_MIN_C) begin
      p_sat = PRES_MIN_C;
      pflag = 1'b1;
    end
    if (p_full > PRES_MAX_C) begin
      p_sat = PRES_MAX_C;
      pflag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      off_s7  <= in_data.off;
      temp_s7 <= in_data.temp;
      // low slice unsigned, high slice signed
      pl_s7   <= PL_W'(in_data.d1) * PL_W'(in_data.sens[SPLIT_W-1:0]);
      ph_s7   <= PH_W'($signed({1'b0, in_data.d1})) *
                 PH_W'($signed(in_data.sens[OFF_W-1:SPLIT_W]));
    end
    if (en8) begin
      off_s8   <= off_s7;
      prod_s8  <= (PROD_W'(ph_s7) <<< SPLIT_W) + PROD_W'($signed({1'b0, pl_s7}));
      temp_s8  <= OT_W'(temp_sat);
      tflag_s8 <= tflag;
    end
    if (en9) begin
      diff_s9  <= DIFF_W'(prod_s8 >>> 21) - DIFF_W'(off_s8);
      temp_s9  <= temp_s8;
      tflag_s9 <= tflag_s8;
    end
    if (en10) begin
      out_temp <= temp_s9;
      out_pres <= OP_W'(p_sat);
      out_flag <= tflag_s9 || pflag;
    end
  end

  assign out_valid = v10;

  a_temp_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_temp >= -15'sd4000 && out_temp <= 15'sd8500))
    else $error("temperature result outside clamp range");

  a_pres_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pres >= 17'd1000 && out_pres <= 17'd120000))
    else $error("pressure result outside clamp range");

  a_hold_stage9 : assert property (@(posedge clk) disable iff (rst)
    (v9 && !en10) |=> (v9 && $stable(diff_s9)))
    else $error("stage 9 item dropped or changed under stall");

endmodule

// ----- rtl/core/baro_pressure_temp_compensation.sv -----
// Throughput: one beat per cycle while m_axis is ready; every one of the ten stages takes a new beat
// each cycle, each stage holding one multiply level or a short adder chain.
// Stalls on m_axis back up stage by stage; empty stages still take new beats.
// Reset (rst, synchronous) clears all stage valid bits and the six
// calibration words to zero.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order barometer compensation: raw D1/D2 to 0.01 degC and 0.01 mbar.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*RAW_W-1:0]   s_axis_tdata,   // raw_pressure, raw_temperature
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OT_W+OP_W-1:0] m_axis_tdata,   // temperature_centideg, pressure_centimbar
  output logic                 m_axis_tuser    // out_of_range
);

  cal_t cal;

  logic    f_valid, f_ready;
  front_t  f_data;
  logic    s_valid, s_ready;
  second_t s_data;

  logic signed [OT_W-1:0] out_temp;
  logic        [OP_W-1:0] out_pres;
  logic                   out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  bptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .raw_pressure    (s_axis_tdata[RAW_W-1:0]),
    .raw_temperature (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .cal             (cal),
    .out_valid       (f_valid),
    .out_ready       (f_ready),
    .out_data        (f_data)
  );

  bptc_second u_second (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  bptc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_temp  (out_temp),
    .out_pres  (out_pres),
    .out_flag  (out_flag)
  );

  assign m_axis_tdata = {out_pres, out_temp};
  assign m_axis_tuser = out_flag;

endmodule
